@@ design/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types, codes and helpers of the table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

   localparam int DATA_W       = 48;
   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 8;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;
   localparam int Q_FRAC       = 24;
   localparam int MAG_W        = DATA_W + 1;
   localparam int DIVW         = 2 * MAG_W;
   localparam int HALF_W       = 25;

   localparam logic [2:0] KIND_LOAD = 3'd0;
   localparam logic [2:0] KIND_ALL  = 3'd1;
   localparam logic [2:0] KIND_ONE  = 3'd2;
   localparam logic [2:0] KIND_INV  = 3'd3;
   localparam logic [2:0] KIND_NEAR = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [DATA_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic [2:0]               kind;
      logic [2:0]               key_column;
      logic [2:0]               dest_column;
      logic signed [DATA_W-1:0] probe;
      logic [7:0]               entry_row;
      logic signed [DATA_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [2:0]               out_column;
      logic signed [DATA_W-1:0] out_value;
      logic signed [DATA_W-1:0] out_slope;
      logic [7:0]               bracket_row;
      logic                     last;
   } rsp_type;

   // signed result from quotient magnitude, saturated to 48 bits
   function automatic logic [DATA_W-1:0] sat_quot(logic [DATA_W-1:0] q, logic over,
                                                   logic neg);
      logic [DATA_W-1:0] res;
      if (neg) begin
         if (over || q > NEG_MIN) res = NEG_MIN;
         else res = -q;
      end else begin
         if (over || q[DATA_W-1]) res = POS_MAX;
         else res = q;
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] sat_sum(logic signed [DATA_W:0] s);
      logic [DATA_W-1:0] res;
      if (s > $signed({1'b0, POS_MAX})) res = POS_MAX;
      else if (s < $signed({1'b1, NEG_MIN})) res = NEG_MIN;
      else res = s[DATA_W-1:0];
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Column-major table in one synchronous memory, hunting bracket search from
// the cached row, then per-column interpolation with a shared bit-serial
// divider and a multiplier that sums four partial products.
// ----------------------------------------------------------------------------
// sequence: a load is written while idle; a probe reads the cached row, hunts
//   row by row and selects the bracket, then per column reads a row value, or
//   for an interpolated one reads both rows, divides, multiplies, divides again
// throughput: one transaction at a time; the memory gives one read per cycle
// reset: synchronous, clears control state; table contents stay unknown
`default_nettype none

module table_linear_interpolator
   import tli_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DIVW);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_SEL   = 4'd3;
   localparam logic [3:0] ST_COL0  = 4'd4;
   localparam logic [3:0] ST_COL1  = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;
   logic [CIW-1:0]    rd_col;
   logic [RIW-1:0]    rd_row;

   logic [3:0]               state_ff, state_in;
   logic [2:0]               kind_ff, kind_in;
   logic [CIW-1:0]           kc_ff, kc_in, dc_ff, dc_in, k_ff, k_in;
   logic signed [DATA_W-1:0] v_ff, v_in;
   logic [RIW-1:0]           cached_ff, cached_in, p_ff, p_in, lo_ff, lo_in;
   logic [RIW-1:0]           row_ff, row_in;
   logic [RCW-1:0]           rc_ff, rc_in;
   logic [CCW-1:0]           cc_ff, cc_in;
   logic                     up_ff, up_in, found_ff, found_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in, x0_ff, x0_in, x1_ff, x1_in;
   logic signed [DATA_W-1:0] y0_ff, y0_in;
   logic signed [DATA_W:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [DATA_W-1:0]        val_ff, val_in, slope_ff, slope_in;
   logic                     phase_ff, phase_in, neg_ff, neg_in;
   logic [DIVW-1:0]          dvd_ff, dvd_in;
   logic [MAG_W-1:0]         dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DATA_W-1:0]        q_ff, q_in;
   logic                     over_ff, over_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic [MAG_W-1:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic [2*HALF_W-1:0]      pp_ff, pp_in;
   logic [DIVW-1:0]          acc_ff, acc_in;
   logic [2:0]               mc_ff, mc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  out_ff, out_in;

   function automatic logic [AW-1:0] addr_of(logic [CIW-1:0] c, logic [RIW-1:0] r);
      return AW'(int'(c) * MAX_ROWS + int'(r));
   endfunction

   function automatic logic [CIW-1:0] clamp_col(logic [2:0] c, logic [CCW-1:0] n);
      logic [CIW-1:0] res;
      if (int'(c) >= int'(n)) res = CIW'(n - 1'b1);
      else res = CIW'(c);
      return res;
   endfunction

   function automatic logic [MAG_W-1:0] mag(logic signed [DATA_W:0] s);
      return s[DATA_W] ? MAG_W'(-s) : MAG_W'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[addr_of(rd_col, rd_row)];
   end

   logic signed [DATA_W-1:0] xr;
   logic                     inv, hit, go_up, last_col;
   logic [RIW-1:0]           cstart, row_a;
   logic signed [DATA_W:0]   d0, d1, vdx, sum;
   logic [CIW-1:0]           kstart;
   logic [MAG_W:0]           r2;
   logic                     ge;
   logic [DATA_W-1:0]        quot;
   logic [HALF_W-1:0]        pa, pb;
   logic [6:0]               sh;

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; kc_in = kc_ff; dc_in = dc_ff; k_in = k_ff;
      v_in = v_ff; cached_in = cached_ff; p_in = p_ff; lo_in = lo_ff; row_in = row_ff;
      rc_in = rc_ff; cc_in = cc_ff; up_in = up_ff; found_in = found_ff;
      prev_in = prev_ff; x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff;
      dx_in = dx_ff; dy_in = dy_ff; val_in = val_ff; slope_in = slope_ff;
      phase_in = phase_ff; neg_in = neg_ff; dvd_in = dvd_ff; dvs_in = dvs_ff;
      rem_in = rem_ff; q_in = q_ff; over_in = over_ff; cnt_in = cnt_ff;
      ma_in = ma_ff; mb_in = mb_ff; pp_in = pp_ff; acc_in = acc_ff; mc_in = mc_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mem_we = 1'b0;
      waddr = addr_of(CIW'(req_data.dest_column), RIW'(req_data.entry_row));
      wdata = req_data.entry_value;
      rd_col = kc_ff;
      rd_row = p_ff;
      req_stall = (state_ff != ST_IDLE);

      xr = $signed(rdata_ff);
      inv = (kind_ff == KIND_INV);
      hit = 1'b0; go_up = 1'b0; last_col = 1'b0;
      cstart = '0; row_a = '0; kstart = '0;
      d0 = '0; d1 = '0; vdx = '0; sum = '0;
      r2 = '0; ge = 1'b0; quot = '0; pa = '0; pb = '0; sh = '0;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.kind) inside
                  KIND_LOAD: begin
                     if (int'(req_data.dest_column) < MAX_COLS
                         && int'(req_data.entry_row) < MAX_ROWS) begin
                        mem_we = 1'b1;
                     end
                  end
                  KIND_ALL, KIND_ONE, KIND_INV, KIND_NEAR: begin
                     cstart = (int'(cached_ff) >= int'(rc_ff)) ? RIW'(rc_ff - 1'b1)
                                                              : cached_ff;
                     kind_in = req_data.kind;
                     kc_in = clamp_col(req_data.key_column, cc_ff);
                     dc_in = clamp_col(req_data.dest_column, cc_ff);
                     v_in = req_data.probe;
                     cached_in = cstart;
                     p_in = cstart;
                     rd_col = clamp_col(req_data.key_column, cc_ff);
                     rd_row = cstart;
                     state_in = ST_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START, ST_SCAN: begin
            if (state_ff == ST_START) begin
               go_up = inv ? !(v_ff > xr) : (v_ff >= xr);
               up_in = go_up;
            end else begin
               go_up = up_ff;
               if (up_ff) hit = inv ? (v_ff >= xr) : (v_ff < xr);
               else hit = inv ? (v_ff <= xr) : (v_ff >= xr);
            end
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_SEL;
               if (up_ff) begin
                  lo_in = p_ff - 1'b1;
                  x0_in = prev_ff;
                  x1_in = xr;
                  cached_in = inv ? p_ff : p_ff - 1'b1;
               end else begin
                  lo_in = p_ff;
                  x0_in = xr;
                  x1_in = prev_ff;
                  cached_in = p_ff;
               end
            end else begin
               prev_in = xr;
               if (go_up) begin
                  if (int'(p_ff) + 1 < int'(rc_ff)) begin
                     p_in = p_ff + 1'b1;
                     rd_row = p_ff + 1'b1;
                     state_in = ST_SCAN;
                  end else begin
                     found_in = 1'b0;
                     cached_in = RIW'(rc_ff - 1'b1);
                     state_in = ST_SEL;
                  end
               end else begin
                  if (p_ff != '0) begin
                     p_in = p_ff - 1'b1;
                     rd_row = p_ff - 1'b1;
                     state_in = ST_SCAN;
                  end else begin
                     found_in = 1'b0;
                     cached_in = '0;
                     state_in = ST_SEL;
                  end
               end
            end
         end
         ST_SEL: begin
            d0 = {v_ff[DATA_W-1], v_ff} - {x0_ff[DATA_W-1], x0_ff};
            d1 = {x1_ff[DATA_W-1], x1_ff} - {v_ff[DATA_W-1], v_ff};
            if (!found_ff) row_a = cached_ff;
            else if (kind_ff == KIND_NEAR) row_a = (d0 > d1) ? lo_ff + 1'b1 : lo_ff;
            else row_a = lo_ff;
            kstart = (kind_ff == KIND_ALL || kind_ff == KIND_NEAR) ? '0 : dc_ff;
            row_in = row_a;
            k_in = kstart;
            rd_col = kstart;
            rd_row = row_a;
            state_in = ST_COL0;
         end
         ST_COL0: begin
            if (found_ff && kind_ff != KIND_NEAR) begin
               y0_in = xr;
               rd_col = k_ff;
               rd_row = row_ff + 1'b1;
               state_in = ST_COL1;
            end else begin
               val_in = rdata_ff;
               slope_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_COL1: begin
            dx_in = {x1_ff[DATA_W-1], x1_ff} - {x0_ff[DATA_W-1], x0_ff};
            dy_in = {xr[DATA_W-1], xr} - {y0_ff[DATA_W-1], y0_ff};
            if (dx_in == '0) begin
               val_in = y0_ff;
               slope_in = '0;
               state_in = ST_OUT;
            end else begin
               dvd_in = DIVW'(mag(dy_in)) << Q_FRAC;
               dvs_in = mag(dx_in);
               neg_in = dy_in[DATA_W] ^ dx_in[DATA_W];
               rem_in = '0; q_in = '0; over_in = 1'b0; cnt_in = '0;
               phase_in = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            r2 = {rem_ff, dvd_ff[DIVW-1]};
            ge = (r2 >= {1'b0, dvs_ff});
            rem_in = ge ? MAG_W'(r2 - {1'b0, dvs_ff}) : MAG_W'(r2);
            q_in = {q_ff[DATA_W-2:0], ge};
            over_in = over_ff | q_ff[DATA_W-1];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == DIVW - 1) begin
               quot = sat_quot(q_in, over_in, neg_ff);
               if (!phase_ff) begin
                  slope_in = quot;
                  vdx = {v_ff[DATA_W-1], v_ff} - {x0_ff[DATA_W-1], x0_ff};
                  ma_in = mag(dy_ff);
                  mb_in = mag(vdx);
                  neg_in = dy_ff[DATA_W] ^ vdx[DATA_W] ^ dx_ff[DATA_W];
                  acc_in = '0;
                  mc_in = '0;
                  state_in = ST_MUL;
               end else begin
                  sum = {y0_ff[DATA_W-1], y0_ff} + {quot[DATA_W-1], quot};
                  val_in = sat_sum(sum);
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            pa = mc_ff[1] ? HALF_W'(ma_ff[MAG_W-1:HALF_W]) : ma_ff[HALF_W-1:0];
            pb = mc_ff[0] ? HALF_W'(mb_ff[MAG_W-1:HALF_W]) : mb_ff[HALF_W-1:0];
            pp_in = pa * pb;
            sh = 7'(HALF_W) * 7'(mc_ff - 1'b1 == 3'd3 ? 2 : (mc_ff - 1'b1 == 3'd0 ? 0 : 1));
            if (mc_ff != '0) begin
               acc_in = acc_ff + (DIVW'(pp_ff) << sh);
            end
            mc_in = mc_ff + 1'b1;
            if (mc_ff == 3'd4) begin
               dvd_in = acc_in;
               rem_in = '0; q_in = '0; over_in = 1'b0; cnt_in = '0;
               phase_in = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            last_col = (kind_ff == KIND_ALL || kind_ff == KIND_NEAR)
                       ? (int'(k_ff) + 1 == int'(cc_ff)) : 1'b1;
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in.out_column = 3'(k_ff);
               out_in.out_value = val_ff;
               out_in.out_slope = slope_ff;
               out_in.bracket_row = 8'(cached_ff);
               out_in.last = last_col;
               rsp_valid_in = 1'b1;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  rd_col = k_ff + 1'b1;
                  rd_row = row_ff;
                  state_in = ST_COL0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               if (csr_wdata == '0) rc_in = RCW'(1);
               else if (int'(csr_wdata) > MAX_ROWS) rc_in = RCW'(MAX_ROWS);
               else rc_in = RCW'(csr_wdata);
               cached_in = RIW'(rc_in >> 1);
            end
            CSR_COL_COUNT: begin
               if (csr_wdata[3:0] == '0) cc_in = CCW'(1);
               else if (int'(csr_wdata[3:0]) > MAX_COLS) cc_in = CCW'(MAX_COLS);
               else cc_in = CCW'(csr_wdata[3:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cached_ff <= '0;
         rc_ff <= RCW'(1);
         cc_ff <= CCW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cached_ff <= cached_in;
         rc_ff <= rc_in;
         cc_ff <= cc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in; kc_ff <= kc_in; dc_ff <= dc_in; k_ff <= k_in; v_ff <= v_in;
      p_ff <= p_in; lo_ff <= lo_in; row_ff <= row_in; up_ff <= up_in;
      found_ff <= found_in; prev_ff <= prev_in; x0_ff <= x0_in; x1_ff <= x1_in;
      y0_ff <= y0_in; dx_ff <= dx_in; dy_ff <= dy_in; val_ff <= val_in;
      slope_ff <= slope_in; phase_ff <= phase_in; neg_ff <= neg_in;
      dvd_ff <= dvd_in; dvs_ff <= dvs_in; rem_ff <= rem_in; q_ff <= q_in;
      over_ff <= over_in; cnt_ff <= cnt_in; ma_ff <= ma_in; mb_ff <= mb_in;
      pp_ff <= pp_in; acc_ff <= acc_in; mc_ff <= mc_in; out_ff <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = out_ff;

endmodule

`default_nettype wire

@@ design/tli_checker.sv @@
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_checker
   import tli_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result dropped without transaction");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == KIND_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

`default_nettype wire

@@ bench/table_linear_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator_tb
// Loads small tables, then drives lookups of every kind and compares each
// result against a local model of the hunt search and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator_tb;
   import tli_pkg::*;

   typedef logic signed [DATA_W-1:0] q48_t;
   typedef logic signed [63:0]       s64_t;
   typedef logic signed [127:0]      s128_t;

   localparam s128_t WIDE_MAX = 128'sh7FFF_FFFF_FFFF;
   localparam s128_t WIDE_MIN = -WIDE_MAX - 1;
   localparam int    QUIET_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   q48_t    table_mem [8][256];
   int      bracket;
   int      row_count = 1;
   int      col_count = 1;
   rsp_type pending_results [$];
   int      fails = 0;
   bit      idle_on = 1'b1;
   int      hold_cycles = 0;
   int      quiet = 0;

   table_linear_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------ model

   function automatic q48_t clip48(s128_t x);
      if (x > WIDE_MAX) return q48_t'(WIDE_MAX);
      if (x < WIDE_MIN) return q48_t'(WIDE_MIN);
      return q48_t'(x);
   endfunction

   function automatic q48_t scaled_ratio(s64_t a, s64_t b, s64_t c);
      s128_t wa, wb, wc;
      wa = a;
      wb = b;
      wc = c;
      return clip48(wa * wb / wc);
   endfunction

   function automatic bit hunt_ascending(int kc, s64_t v);
      int   b;
      s64_t x;
      b = bracket;
      x = table_mem[kc][b];
      if (v >= x) begin
         for (int i = b + 1; i < row_count; i++) begin
            x = table_mem[kc][i];
            if (v < x) begin
               bracket = i - 1;
               return 1'b1;
            end
         end
         bracket = row_count - 1;
         return 1'b0;
      end
      for (int i = b; i > 0; i--) begin
         x = table_mem[kc][i-1];
         if (v >= x) begin
            bracket = i - 1;
            return 1'b1;
         end
      end
      bracket = 0;
      return 1'b0;
   endfunction

   function automatic bit hunt_descending(int kc, s64_t v, output int lo, output int hi);
      int   b;
      s64_t x;
      b = bracket;
      x = table_mem[kc][b];
      lo = 0;
      hi = 0;
      if (v > x) begin
         for (int i = b; i > 0; i--) begin
            x = table_mem[kc][i-1];
            if (v <= x) begin
               bracket = i - 1;
               lo = i - 1;
               hi = i;
               return 1'b1;
            end
         end
         bracket = 0;
         return 1'b0;
      end
      for (int i = b + 1; i < row_count; i++) begin
         x = table_mem[kc][i];
         if (v >= x) begin
            bracket = i;
            lo = i - 1;
            hi = i;
            return 1'b1;
         end
      end
      bracket = row_count - 1;
      return 1'b0;
   endfunction

   function automatic void lerp(int lo, int hi, int kc, int dc, s64_t v,
                                output q48_t val, output q48_t slope);
      s64_t  x0, x1, y0, y1, dx, dy;
      s128_t sum;
      x0 = table_mem[kc][lo];
      x1 = table_mem[kc][hi];
      y0 = table_mem[dc][lo];
      y1 = table_mem[dc][hi];
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx == 0) begin
         val = q48_t'(y0);
         slope = '0;
         return;
      end
      slope = scaled_ratio(dy, s64_t'(1) <<< 24, dx);
      sum = y0;
      sum = sum + scaled_ratio(dy, v - x0, dx);
      val = clip48(sum);
   endfunction

   function automatic void push_result(int col, q48_t val, q48_t slope, bit last);
      rsp_type r;
      r.out_column  = col[2:0];
      r.out_value   = val;
      r.out_slope   = slope;
      r.bracket_row = bracket[7:0];
      r.last        = last;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_lookup(req_type t);
      int   kc, dc, lo, hi, pick;
      bit   found, up;
      s64_t v, x0, x1;
      q48_t val, slope;
      kc = t.key_column;
      dc = t.dest_column;
      v  = t.probe;
      if (t.kind == KIND_LOAD) begin
         table_mem[dc][t.entry_row] = t.entry_value;
         return;
      end
      if (t.kind > KIND_NEAR) return;
      if (kc >= col_count) kc = col_count - 1;
      if (dc >= col_count) dc = col_count - 1;
      if (bracket >= row_count) bracket = row_count - 1;
      case (t.kind) inside
         KIND_ALL, KIND_ONE: begin
            found = hunt_ascending(kc, v);
            lo = bracket;
            hi = bracket + 1;
            for (int k = 0; k < col_count; k++) begin
               if (t.kind == KIND_ONE && k != dc) continue;
               if (found) lerp(lo, hi, kc, k, v, val, slope);
               else begin
                  val = table_mem[k][lo];
                  slope = '0;
               end
               push_result(k, val, slope, t.kind == KIND_ONE || k + 1 == col_count);
            end
         end
         KIND_INV: begin
            found = hunt_descending(kc, v, lo, hi);
            if (found) lerp(lo, hi, kc, dc, v, val, slope);
            else begin
               val = table_mem[dc][bracket];
               slope = '0;
            end
            push_result(dc, val, slope, 1'b1);
         end
         default: begin
            x0 = table_mem[kc][bracket];
            up = v >= x0;
            found = hunt_ascending(kc, v);
            if (found) begin
               x0 = table_mem[kc][bracket];
               x1 = table_mem[kc][bracket+1];
               pick = (v - x0) > (x1 - v) ? bracket + 1 : bracket;
            end else begin
               pick = up ? row_count - 1 : 0;
            end
            for (int k = 0; k < col_count; k++)
               push_result(k, table_mem[k][pick], '0, k + 1 == col_count);
         end
      endcase
   endfunction

   // ------------------------------------------------------------ drivers

   task automatic send_item(req_type t);
      while (idle_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lookup(t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      logic [CSR_DATA_W-1:0] d;
      d = value[CSR_DATA_W-1:0];
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ROW_COUNT) begin
         row_count = d == 0 ? 1 : (d > 256 ? 256 : int'(d));
         bracket = row_count / 2;
      end else begin
         col_count = d[3:0] == 0 ? 1 : (d[3:0] > 8 ? 8 : int'(d[3:0]));
      end
   endtask

   function automatic q48_t rand48();
      logic [63:0] x;
      x = {$urandom, $urandom};
      return x[47:0];
   endfunction

   function automatic req_type make_item(logic [2:0] kind, int kc, int dc, q48_t v);
      req_type t;
      t.kind        = kind;
      t.key_column  = kc[2:0];
      t.dest_column = dc[2:0];
      t.probe       = v;
      t.entry_row   = $urandom_range(255);
      t.entry_value = rand48();
      return t;
   endfunction

   task automatic load_entry(int col, int row, q48_t val);
      req_type t;
      t = make_item(KIND_LOAD, $urandom_range(7), col, rand48());
      t.entry_row   = row[7:0];
      t.entry_value = val;
      send_item(t);
   endtask

   // key column 0 ascends, column 1 descends, the rest are free
   task automatic fill_table(int rows, int cols);
      s64_t x, step;
      for (int c = 0; c < cols; c++) begin
         x = -s64_t'($urandom_range(0, 1 << 30)) <<< 10;
         for (int r = 0; r < rows; r++) begin
            step = $urandom_range(7) == 0 ? 0 :
                   s64_t'($urandom_range(1, 100000)) <<< $urandom_range(0, 20);
            if (c == 0) x = x + step;
            else if (c == 1) x = x - step;
            else x = $urandom_range(3) == 0 ? s64_t'(rand48()) :
                     s64_t'($signed($urandom)) <<< $urandom_range(0, 15);
            load_entry(c, r, q48_t'(x));
         end
      end
   endtask

   function automatic q48_t pick_probe(int kc);
      int          sel, r, r2;
      s64_t        a, b, lo;
      logic [63:0] span;
      if (kc >= col_count) kc = col_count - 1;
      sel = $urandom_range(99);
      r   = $urandom_range(row_count - 1);
      r2  = r + 1 < row_count ? r + 1 : r;
      if (sel < 8) return q48_t'(POS_MAX);
      if (sel < 16) return q48_t'(NEG_MIN);
      if (sel < 36) return table_mem[kc][r];
      if (sel < 46) return rand48();
      a = table_mem[kc][r];
      b = table_mem[kc][r2];
      lo = a < b ? a : b;
      span = a < b ? b - a : a - b;
      return q48_t'(lo + s64_t'({$urandom, $urandom} % (span + 1)));
   endfunction

   task automatic random_lookups(int n);
      int         sel, kc;
      logic [2:0] kind;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         kc  = $urandom_range(7);
         if (sel < 5)
            load_entry($urandom_range(col_count - 1), $urandom_range(row_count - 1),
                       $urandom_range(1) ? rand48() : q48_t'(pick_probe(kc)));
         else begin
            kind = sel < 8 ? 3'($urandom_range(5, 7)) :
                   sel < 30 ? KIND_ALL : sel < 55 ? KIND_ONE :
                   sel < 78 ? KIND_INV : KIND_NEAR;
            send_item(make_item(kind, kc, $urandom_range(7), pick_probe(kc)));
         end
      end
   endtask

   // ------------------------------------------------------------ receive side

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else rsp_stall <= idle_on && ($urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: %p", rsp_data);
            fails++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_data.out_column !== e.out_column) begin
               $error("out_column expected %0d got %0d", e.out_column, rsp_data.out_column);
               fails++;
            end
            if (rsp_data.out_value !== e.out_value) begin
               $error("out_value expected %0d got %0d", e.out_value, rsp_data.out_value);
               fails++;
            end
            if (rsp_data.out_slope !== e.out_slope) begin
               $error("out_slope expected %0d got %0d", e.out_slope, rsp_data.out_slope);
               fails++;
            end
            if (rsp_data.bracket_row !== e.bracket_row) begin
               $error("bracket_row expected %0d got %0d", e.bracket_row,
                      rsp_data.bracket_row);
               fails++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_data.last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet = 0;
      else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("table_linear_interpolator: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------ tests

   task automatic test_single_row();
      write_csr(CSR_ROW_COUNT, 0);
      write_csr(CSR_COL_COUNT, 0);
      load_entry(0, 0, 48'sh0000_0123_4567);
      send_item(make_item(KIND_ALL, 0, 0, q48_t'(POS_MAX)));
      send_item(make_item(KIND_ONE, 0, 0, q48_t'(NEG_MIN)));
      send_item(make_item(KIND_INV, 0, 0, '0));
      send_item(make_item(KIND_NEAR, 7, 7, 48'sd5));
      for (int k = 5; k < 8; k++) send_item(make_item(3'(k), 0, 0, rand48()));
      drain();
   endtask

   task automatic test_small_table();
      q48_t keys [4]  = '{48'sd0, 48'sd10 <<< 24, 48'sd10 <<< 24, 48'sd20 <<< 24};
      q48_t falls [4] = '{48'sd100 <<< 24, 48'sd50 <<< 24, 48'sd50 <<< 24,
                          -(48'sd50 <<< 24)};
      q48_t wild [4]  = '{q48_t'(POS_MAX), q48_t'(NEG_MIN), 48'sd0, q48_t'(POS_MAX)};
      write_csr(CSR_ROW_COUNT, 4);
      write_csr(CSR_COL_COUNT, 3);
      for (int r = 0; r < 4; r++) begin
         load_entry(0, r, keys[r]);
         load_entry(1, r, falls[r]);
         load_entry(2, r, wild[r]);
      end
      send_item(make_item(KIND_ALL, 0, 0, 48'sd5 <<< 24));
      send_item(make_item(KIND_ALL, 0, 0, -48'sd1));
      send_item(make_item(KIND_ALL, 0, 0, q48_t'(POS_MAX)));
      send_item(make_item(KIND_ONE, 0, 2, 48'sd9 <<< 24));
      send_item(make_item(KIND_ONE, 7, 7, 48'sd15 <<< 24));
      send_item(make_item(KIND_INV, 1, 0, 48'sd50 <<< 24));
      send_item(make_item(KIND_INV, 1, 2, 48'sd200 <<< 24));
      send_item(make_item(KIND_INV, 1, 0, q48_t'(NEG_MIN)));
      send_item(make_item(KIND_NEAR, 0, 0, 48'sd5 <<< 24));
      send_item(make_item(KIND_NEAR, 0, 0, 48'sd6 <<< 24));
      send_item(make_item(KIND_NEAR, 0, 0, q48_t'(NEG_MIN)));
      send_item(make_item(KIND_NEAR, 0, 0, q48_t'(POS_MAX)));
      drain();
   endtask

   // full row count starts the hunt at row 128, probes stay inside its bracket
   task automatic test_register_limits();
      write_csr(CSR_ROW_COUNT, 300);
      write_csr(CSR_COL_COUNT, 1);
      load_entry(0, 128, 48'sd1 <<< 24);
      load_entry(0, 129, 48'sd3 <<< 24);
      send_item(make_item(KIND_ALL, 0, 0, 48'sd2 <<< 24));
      send_item(make_item(KIND_NEAR, 0, 0, 48'sd5 <<< 23));
      drain();
      write_csr(CSR_ROW_COUNT, 512 + 5);
      write_csr(CSR_COL_COUNT, 15);
      fill_table(5, 8);
      random_lookups(10);
      drain();
   endtask

   task automatic test_random_settings();
      int rows [4] = '{8, 2, 6, 4};
      int cols [4] = '{3, 2, 2, 3};
      for (int s = 0; s < 4; s++) begin
         write_csr(CSR_ROW_COUNT, rows[s]);
         write_csr(CSR_COL_COUNT, cols[s]);
         fill_table(rows[s], cols[s]);
         random_lookups(12);
         drain();
      end
   endtask

   task automatic test_back_pressure();
      idle_on = 1'b0;
      hold_cycles = 400;
      random_lookups(12);
      drain();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_row();
      test_small_table();
      test_register_limits();
      test_random_settings();
      test_back_pressure();
      repeat (20) @(posedge clock);
      if (fails == 0)
         $display("table_linear_interpolator: match");
      else
         $display("table_linear_interpolator: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/tli_pkg.sv
design/table_linear_interpolator.sv
design/tli_checker.sv
bench/table_linear_interpolator_tb.sv
